// ----- rtl/core/sxlt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sxlt_pkg
// Types, codes and sizes shared by the shared/exclusive lock table.
// ----------------------------------------------------------------------------
package sxlt_pkg;

	localparam int KIND_W          = 3;
	localparam int XID_W           = 32;
	localparam int STATUS_W        = 3;
	localparam int MAX_HOLDERS_DEF = 64;
	localparam int QUEUE_DEPTH     = 2;

	// request kind codes as they arrive on the port
	localparam logic [KIND_W-1:0] KIND_TAKE_SH = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REL_SH  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TAKE_EX = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REL_EX  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd4;

	typedef enum logic [2:0] {
		OP_TAKE_SH,
		OP_REL_SH,
		OP_TAKE_EX,
		OP_REL_EX,
		OP_QUERY,
		OP_NOP
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE       = 3'd0,
		ST_BUSY       = 3'd1,
		ST_FULL       = 3'd2,
		ST_NOT_HOLDER = 3'd3,
		ST_NO_SHARED  = 3'd4
	} status_t;

	// classified request passed from front to back
	typedef struct packed {
		op_t              op;
		logic             zero_id;
		logic [XID_W-1:0] xid;
	} req_t;

	typedef struct packed {
		status_t status;
		logic    held;
		logic    held_x;
	} res_t;

endpackage : sxlt_pkg
`default_nettype wire

// ----- rtl/core/sxlt_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sxlt_queue
// Small register queue with full/empty flags.
// ----------------------------------------------------------------------------
module sxlt_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	output logic              full,
	input  wire logic         rd_en,
	output logic [W-1:0]      rd_data,
	output logic              empty
);
	import sxlt_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule : sxlt_queue
`default_nettype wire

// ----- rtl/core/sxlt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sxlt_front
// Accepts requests, decodes kind and flags the reserved id, then queues them.
// ----------------------------------------------------------------------------
module sxlt_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [sxlt_pkg::KIND_W-1:0]  kind,
	input  wire logic [sxlt_pkg::XID_W-1:0]   xid,
	input  wire logic                         req_pop,
	output sxlt_pkg::req_t                    req,
	output logic                              req_empty
);
	import sxlt_pkg::*;

	req_t cls;
	logic wr_en;

	always_comb begin
		case (kind)
			KIND_TAKE_SH: cls.op = OP_TAKE_SH;
			KIND_REL_SH:  cls.op = OP_REL_SH;
			KIND_TAKE_EX: cls.op = OP_TAKE_EX;
			KIND_REL_EX:  cls.op = OP_REL_EX;
			KIND_QUERY:   cls.op = OP_QUERY;
			default:      cls.op = OP_NOP;
		endcase
		cls.zero_id = (xid == '0);
		cls.xid     = xid;
	end

	assign wr_en = push && !full;

	sxlt_queue #(
		.W($bits(req_t))
	) u_req_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (cls),
		.full    (full),
		.rd_en   (req_pop),
		.rd_data (req),
		.empty   (req_empty)
	);

endmodule : sxlt_front
`default_nettype wire

// ----- rtl/core/sxlt_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sxlt_back
// Lock state and holder table; executes one request per cycle unless res_full.
// ----------------------------------------------------------------------------
module sxlt_back #(
	parameter int MAX_HOLDERS = sxlt_pkg::MAX_HOLDERS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sxlt_pkg::req_t  req,
	input  wire logic            req_empty,
	output logic                 req_pop,
	input  wire logic            res_full,
	output logic                 res_push,
	output sxlt_pkg::res_t       res
);
	import sxlt_pkg::*;

	localparam int CNT_W = $clog2(MAX_HOLDERS + 1);

	logic                   excl_q;
	logic [XID_W-1:0]       owner_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [MAX_HOLDERS-1:0] occ_q;
	logic [XID_W-1:0]       slot_q [MAX_HOLDERS];

	logic [MAX_HOLDERS-1:0] hit_vec;
	logic [MAX_HOLDERS-1:0] free_vec;
	logic [MAX_HOLDERS-1:0] hit_first;
	logic [MAX_HOLDERS-1:0] free_first;
	logic                   owner_match;

	logic                   set_slot;
	logic                   clr_slot;
	logic                   set_excl;
	logic                   clr_excl;

	assign req_pop  = !req_empty && !res_full;
	assign res_push = req_pop;

	always_comb begin
		for (int i = 0; i < MAX_HOLDERS; i++) begin
			hit_vec[i]  = occ_q[i] && (slot_q[i] == req.xid);
			free_vec[i] = !occ_q[i];
		end
	end

	// lowest set bit, one-hot
	assign hit_first   = hit_vec & (~hit_vec + MAX_HOLDERS'(1));
	assign free_first  = free_vec & (~free_vec + MAX_HOLDERS'(1));
	assign owner_match = excl_q && (owner_q == req.xid);

	always_comb begin
		res.status = ST_DONE;
		res.held   = 1'b0;
		res.held_x = 1'b0;
		set_slot   = 1'b0;
		clr_slot   = 1'b0;
		set_excl   = 1'b0;
		clr_excl   = 1'b0;
		case (req.op)
			OP_TAKE_SH: begin
				if (req.zero_id || excl_q) begin
					res.status = ST_BUSY;
				end else if (free_vec == '0) begin
					res.status = ST_FULL;
				end else begin
					set_slot = 1'b1;
				end
			end
			OP_REL_SH: begin
				if (cnt_q == '0) begin
					res.status = ST_NO_SHARED;
				end else if (req.zero_id || hit_vec == '0) begin
					res.status = ST_NOT_HOLDER;
				end else begin
					clr_slot = 1'b1;
				end
			end
			OP_TAKE_EX: begin
				if (req.zero_id || excl_q || cnt_q != '0) begin
					res.status = ST_BUSY;
				end else begin
					set_excl = 1'b1;
				end
			end
			OP_REL_EX: begin
				if (req.zero_id || !owner_match) begin
					res.status = ST_NOT_HOLDER;
				end else begin
					clr_excl = 1'b1;
				end
			end
			OP_QUERY: begin
				if (!req.zero_id) begin
					res.held_x = owner_match;
					res.held   = owner_match || (hit_vec != '0);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			excl_q <= 1'b0;
			cnt_q  <= '0;
			occ_q  <= '0;
		end else if (req_pop) begin
			if (set_slot) begin
				occ_q <= occ_q | free_first;
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (clr_slot) begin
				occ_q <= occ_q & ~hit_first;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (set_excl) begin
				excl_q <= 1'b1;
			end else if (clr_excl) begin
				excl_q <= 1'b0;
			end
		end
	end

	// owner and slot ids are only looked at while their flag is set
	always_ff @(posedge clk) begin
		if (req_pop && set_excl) begin
			owner_q <= req.xid;
		end
		for (int i = 0; i < MAX_HOLDERS; i++) begin
			if (req_pop && set_slot && free_first[i]) begin
				slot_q[i] <= req.xid;
			end
		end
	end

endmodule : sxlt_back
`default_nettype wire

// ----- rtl/core/shared_exclusive_lock_table.sv -----
`default_nettype none
// Flow: a request is queued, executed by the back end, and its result queued for the pop side.
// Throughput: one request per cycle; the back end executes one request each cycle that the
//   result queue has room, with the whole holder table compared in parallel.
// Reset: arst_n clears the lock flag, shared count and all slot-occupied bits, and empties
//   both queues; the request queue then has room, so requests are taken right away.
// ----------------------------------------------------------------------------
// shared_exclusive_lock_table
// Non-blocking shared/exclusive lock with a table of shared holder ids.
// ----------------------------------------------------------------------------
module shared_exclusive_lock_table #(
	parameter int MAX_HOLDERS = sxlt_pkg::MAX_HOLDERS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request side: a transfer happens when push is high and full is low
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [sxlt_pkg::KIND_W-1:0]    kind,
	input  wire logic [sxlt_pkg::XID_W-1:0]     xid,
	// result side: a transfer happens when pop is high and empty is low
	output logic                                empty,
	input  wire logic                           pop,
	output logic [sxlt_pkg::STATUS_W-1:0]       status,
	output logic                                held,
	output logic                                held_exclusive
);
	import sxlt_pkg::*;

	req_t req;
	logic req_empty;
	logic req_pop;
	res_t res_in;
	res_t res_out;
	logic res_push;
	logic res_full;
	logic res_pop;

	// Front: decode kind, mark the reserved zero id, queue the request.
	sxlt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.xid       (xid),
		.req_pop   (req_pop),
		.req       (req),
		.req_empty (req_empty)
	);

	// Back: lock state, holder table and the grant/deny decision.
	sxlt_back #(
		.MAX_HOLDERS(MAX_HOLDERS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_empty (req_empty),
		.req_pop   (req_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result queue decouples the back end from the consumer's pop.
	assign res_pop = pop && !empty;

	sxlt_queue #(
		.W($bits(res_t))
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (res_pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign status         = res_out.status;
	assign held           = res_out.held;
	assign held_exclusive = res_out.held_x;

endmodule : shared_exclusive_lock_table
`default_nettype wire

// ----- sim/lock_table_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lock_table_checker
// Watches both queue sides of the lock table, predicts each result from its
// own copy of the lock state and compares every popped result in order.
// ----------------------------------------------------------------------------
module lock_table_checker #(
	parameter int MAX_HOLDERS = sxlt_pkg::MAX_HOLDERS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic                          full,
	input  wire logic [sxlt_pkg::KIND_W-1:0]   kind,
	input  wire logic [sxlt_pkg::XID_W-1:0]    xid,
	input  wire logic                          empty,
	input  wire logic                          pop,
	input  wire logic [sxlt_pkg::STATUS_W-1:0] status,
	input  wire logic                          held,
	input  wire logic                          held_exclusive,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 checked_count,
	output int                                 full_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import sxlt_pkg::*;

	logic             excl_held;
	logic [XID_W-1:0] excl_id;
	int unsigned      holder_count;
	logic [XID_W-1:0] holder_ids [MAX_HOLDERS];
	res_t             expected_results [$];

	int fail_total    = 0;
	int checked_total = 0;
	int full_total    = 0;

	assign fail_count    = fail_total;
	assign pending       = expected_results.size();
	assign checked_count = checked_total;
	assign full_count    = full_total;

	// first slot holding key; MAX_HOLDERS when none
	function automatic int slot_of(input logic [XID_W-1:0] key);
		for (int i = 0; i < MAX_HOLDERS; i++)
			if (holder_ids[i] == key)
				return i;
		return MAX_HOLDERS;
	endfunction

	// applies one request to the lock state and returns its result
	function automatic res_t apply_request(input logic [KIND_W-1:0] k,
			input logic [XID_W-1:0] id);
		res_t r;
		int   s;
		r.status = ST_DONE;
		r.held   = 1'b0;
		r.held_x = 1'b0;
		case (k)
		KIND_TAKE_SH: begin
			if (id == '0 || excl_held) begin
				r.status = ST_BUSY;
			end else begin
				s = slot_of('0);
				if (s >= MAX_HOLDERS) begin
					r.status = ST_FULL;
				end else begin
					holder_ids[s] = id;
					holder_count++;
				end
			end
		end
		KIND_REL_SH: begin
			if (holder_count == 0) begin
				r.status = ST_NO_SHARED;
			end else if (id == '0) begin
				r.status = ST_NOT_HOLDER;
			end else begin
				s = slot_of(id);
				if (s >= MAX_HOLDERS) begin
					r.status = ST_NOT_HOLDER;
				end else begin
					holder_ids[s] = '0;
					holder_count--;
				end
			end
		end
		KIND_TAKE_EX: begin
			if (id == '0 || excl_held || holder_count != 0) begin
				r.status = ST_BUSY;
			end else begin
				excl_held = 1'b1;
				excl_id   = id;
			end
		end
		KIND_REL_EX: begin
			if (id == '0 || !excl_held || excl_id != id) begin
				r.status = ST_NOT_HOLDER;
			end else begin
				excl_held = 1'b0;
				excl_id   = '0;
			end
		end
		KIND_QUERY: begin
			if (id != '0) begin
				r.held_x = excl_held && excl_id == id;
				r.held   = r.held_x || slot_of(id) < MAX_HOLDERS;
			end
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			excl_held    = 1'b0;
			excl_id      = '0;
			holder_count = 0;
			foreach (holder_ids[i])
				holder_ids[i] = '0;
			expected_results.delete();
		end else begin
			// a result never belongs to a request taken at the same edge
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: status %0d held %0b held_exclusive %0b",
						status, held, held_exclusive);
					fail_total++;
				end else begin
					want = expected_results.pop_front();
					checked_total++;
					if (want.status == ST_FULL)
						full_total++;
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_total++;
					end
					if (held !== want.held) begin
						$error("held: expected %0b, actual %0b", want.held, held);
						fail_total++;
					end
					if (held_exclusive !== want.held_x) begin
						$error("held_exclusive: expected %0b, actual %0b", want.held_x,
							held_exclusive);
						fail_total++;
					end
				end
			end
			if (push && !full)
				expected_results.push_back(apply_request(kind, xid));
		end
	end

endmodule : lock_table_checker
`default_nettype wire

// ----- sim/tb_shared_exclusive_lock_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_shared_exclusive_lock_table
// Drives lock requests into the table and pops its results, both sides with
// random gaps; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_shared_exclusive_lock_table;
	timeunit 1ns;
	timeprecision 1ps;
	import sxlt_pkg::*;

	localparam int CLK_HALF    = 2;
	localparam int RESET_CYCLES = 12;
	localparam int TARGET_ITEMS = 1850;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int MAX_GAP      = 18;
	localparam int POOL_SIZE    = 8;
	// settle time after the last result
	localparam int TAIL_CYCLES  = 8;

	// kind codes the block decodes as no operation
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                push   = 1'b0;
	logic                pop    = 1'b0;
	logic [KIND_W-1:0]   kind   = '0;
	logic [XID_W-1:0]    xid    = '0;
	logic                full;
	logic                empty;
	logic [STATUS_W-1:0] status;
	logic                held;
	logic                held_exclusive;

	int fail_count;
	int pending;
	int checked_count;
	int full_count;

	// stimulus bookkeeping only: ids that were offered, so they can be handed back
	logic [XID_W-1:0] id_pool [POOL_SIZE];
	logic [XID_W-1:0] shared_tries [$];
	logic [XID_W-1:0] excl_tries [$];

	int lock_requests  = 0;  // transfers with a real lock kind
	int spare_requests = 0;  // transfers with an unused kind
	int cycle_count    = 0;

	// per phase: a steady side never pauses between transfers
	bit push_steady = 1'b0;
	bit pop_steady  = 1'b0;

	always #CLK_HALF clk = ~clk;

	shared_exclusive_lock_table uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.xid            (xid),
		.empty          (empty),
		.pop            (pop),
		.status         (status),
		.held           (held),
		.held_exclusive (held_exclusive)
	);

	lock_table_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.xid            (xid),
		.empty          (empty),
		.pop            (pop),
		.status         (status),
		.held           (held),
		.held_exclusive (held_exclusive),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked_count  (checked_count),
		.full_count     (full_count)
	);

	// Request transfer. Called at a falling edge and returns at one.
	// push is only lowered when a gap is drawn, so a back-to-back
	// transfer never sees push dropped and raised in the same step.
	task automatic send_request(input logic [KIND_W-1:0] k, input logic [XID_W-1:0] id);
		int gap;
		gap = push_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		kind <= k;
		xid  <= id;
		// full is read right at the edge, i.e. the value the block saw
		do @(posedge clk); while (full);
		@(negedge clk);
		if (k <= KIND_QUERY)
			lock_requests++;
		else
			spare_requests++;
	endtask

	// mostly known ids so that takes and releases meet; some zero and wide ids
	function automatic logic [XID_W-1:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 10)
			return $urandom;
		return id_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	// fresh ids per phase: a few small ones, the rest spread over all 32 bits
	task automatic refresh_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = (i < 3) ? XID_W'(i + 1) : XID_W'($urandom | 1);
	endtask

	task automatic take_shared(input logic [XID_W-1:0] id);
		shared_tries.push_back(id);
		send_request(KIND_TAKE_SH, id);
	endtask

	// hand back every shared take and each mixed-phase exclusive take, so the lock
	// ends up free; extra releases come back as not-holder or no-shared
	task automatic release_all();
		logic [XID_W-1:0] id;
		while (shared_tries.size() != 0) begin
			id = shared_tries.pop_front();
			if ($urandom_range(0, 9) == 0)
				send_request(KIND_QUERY, id);
			send_request(KIND_REL_SH, id);
		end
		while (excl_tries.size() != 0)
			send_request(KIND_REL_EX, excl_tries.pop_front());
	endtask

	// fill the holder table past its size, then drain it
	task automatic fill_phase();
		int n;
		release_all();
		n = $urandom_range(MAX_HOLDERS_DEF + 2, MAX_HOLDERS_DEF + 14);
		repeat (n) begin
			take_shared(($urandom_range(0, 19) == 0) ? '0 : id_pool[$urandom_range(0, POOL_SIZE - 1)]);
			if ($urandom_range(0, 6) == 0)
				send_request(KIND_QUERY, pick_id());
		end
		// one exclusive try and a query against the packed table
		send_request(KIND_TAKE_EX, id_pool[0]);
		send_request(KIND_QUERY, id_pool[$urandom_range(0, POOL_SIZE - 1)]);
		release_all();
	endtask

	// exclusive owner cycles with conflicting traffic from others
	task automatic exclusive_phase();
		logic [XID_W-1:0] owner;
		logic [XID_W-1:0] other;
		release_all();
		repeat ($urandom_range(2, 4)) begin
			owner = id_pool[$urandom_range(0, POOL_SIZE - 1)];
			other = pick_id();
			send_request(KIND_TAKE_EX, owner);
			repeat ($urandom_range(1, 5)) begin
				case ($urandom_range(0, 4))
				0: take_shared(other);
				1: send_request(KIND_TAKE_EX, ($urandom_range(0, 1) == 0) ? owner : other);
				2: send_request(KIND_REL_EX, other);
				3: send_request(KIND_REL_SH, other);
				default: send_request(KIND_QUERY, ($urandom_range(0, 1) == 0) ? owner : other);
				endcase
			end
			send_request(KIND_QUERY, owner);
			send_request(KIND_REL_EX, owner);
		end
	endtask

	// weighted random mix over every kind, unused codes included
	task automatic mixed_phase();
		int               r;
		logic [XID_W-1:0] id;
		repeat ($urandom_range(20, 60)) begin
			r  = $urandom_range(0, 99);
			id = pick_id();
			if (r < 30) begin
				take_shared(id);
			end else if (r < 52) begin
				send_request(KIND_REL_SH, id);
			end else if (r < 64) begin
				excl_tries.push_back(id);
				send_request(KIND_TAKE_EX, id);
			end else if (r < 74) begin
				send_request(KIND_REL_EX, id);
			end else if (r < 94) begin
				send_request(KIND_QUERY, id);
			end else begin
				send_request(KIND_SPARE_A + KIND_W'($urandom_range(0, 2)), $urandom);
			end
		end
	endtask

	// cycle counter watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	// result side: pops for the whole run, pausing at random outside steady phases
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = pop_steady ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	// request side and verdict
	initial begin
		int phase;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: corner cases on a fresh lock, both sides idling at random
		send_request(KIND_QUERY,   32'd1);          // nothing held yet
		send_request(KIND_REL_SH,  32'd1);          // release with no holders
		send_request(KIND_TAKE_SH, 32'd1);
		send_request(KIND_TAKE_SH, 32'd1);          // duplicate take fills a second slot
		send_request(KIND_QUERY,   32'd1);
		send_request(KIND_TAKE_EX, 32'd7);          // shared holders block exclusive
		send_request(KIND_REL_SH,  32'd0);          // zero id while holders exist
		send_request(KIND_REL_SH,  32'd9);          // not a holder
		send_request(KIND_REL_SH,  32'd1);
		send_request(KIND_REL_SH,  32'd1);
		send_request(KIND_REL_EX,  32'd1);          // exclusive not held
		send_request(KIND_TAKE_EX, 32'hFFFF_FFFF);
		send_request(KIND_QUERY,   32'hFFFF_FFFF);  // held and held exclusive
		send_request(KIND_TAKE_EX, 32'hFFFF_FFFF);  // same owner again is busy
		send_request(KIND_TAKE_SH, 32'd2);          // shared blocked by exclusive
		send_request(KIND_REL_EX,  32'd2);          // wrong owner
		send_request(KIND_TAKE_SH, 32'd0);          // zero id takes are refused
		send_request(KIND_TAKE_EX, 32'd0);
		send_request(KIND_REL_EX,  32'd0);
		send_request(KIND_QUERY,   32'd0);
		send_request(KIND_REL_EX,  32'hFFFF_FFFF);
		send_request(KIND_SPARE_A, 32'h0000_0005);  // unused kinds are ignored
		send_request(KIND_SPARE_B, 32'hAAAA_AAAA);
		send_request(KIND_SPARE_C, 32'h5555_5555);

		// random phases until the item budget is spent
		while (lock_requests < TARGET_ITEMS) begin
			refresh_pool();
			push_steady = ($urandom_range(0, 3) == 0);
			pop_steady  = ($urandom_range(0, 3) == 0);
			phase = $urandom_range(0, 9);
			if (phase < 3)
				fill_phase();
			else if (phase < 6)
				exclusive_phase();
			else
				mixed_phase();
		end
		release_all();
		push <= 1'b0;

		// drain, then a short tail to catch any stray result
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("%0d lock requests and %0d unused-kind requests sent, %0d results compared",
			lock_requests, spare_requests, checked_count);
		$display("%0d shared takes refused on a full holder table, %0d cycles", full_count,
			cycle_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule : tb_shared_exclusive_lock_table
`default_nettype wire

// ----- files.f -----
rtl/core/sxlt_pkg.sv
rtl/core/sxlt_queue.sv
rtl/core/sxlt_front.sv
rtl/core/sxlt_back.sv
rtl/core/shared_exclusive_lock_table.sv
sim/lock_table_checker.sv
sim/tb_shared_exclusive_lock_table.sv
